>>> hdl/msss_pkg.sv
// Shared definitions for the minimum absolute subset sum search core.
// Holds parameter defaults, result field widths, state codes and the evaluator control word.
// No dependencies.
`default_nettype none
package msss_pkg;

  localparam int DEF_MAX_ELEMENTS = 32;
  localparam int DEF_VALUE_WIDTH  = 57;

  // result field widths, fixed by the interface
  localparam int ABS_OUT_W = 61;
  localparam int CNT_OUT_W = 6;

  // sequencer states, one-hot
  typedef enum logic [9:0] {
    ST_LOAD  = 10'b00_0000_0001,
    ST_BWR   = 10'b00_0000_0010,
    ST_BRD   = 10'b00_0000_0100,
    ST_BUPD  = 10'b00_0000_1000,
    ST_SCAN  = 10'b00_0001_0000,
    ST_NEXT  = 10'b00_0010_0000,
    ST_GRD   = 10'b00_0100_0000,
    ST_GUPD  = 10'b00_1000_0000,
    ST_DRAIN = 10'b01_0000_0000,
    ST_OUT   = 10'b10_0000_0000
  } state_t;

  // control from the sequencer to the candidate evaluator
  typedef struct packed {
    logic clear;
    logic valid;
  } eval_ctl_t;

endpackage
`default_nettype wire

>>> hdl/msss_eval.sv
// Candidate evaluator: forms each combined subset sum, takes its magnitude and
// keeps the best (least magnitude, then fewest members) seen since the last clear.
// Depends on msss_pkg.
`default_nettype none
module msss_eval
  import msss_pkg::*;
#(
  parameter int SUM_W = 63,
  parameter int CW    = 6
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire eval_ctl_t        ctl,
  input  wire logic [SUM_W-1:0] part_sum,
  input  wire logic [CW-1:0]    part_cnt,
  input  wire logic [SUM_W-1:0] tab_sum,
  input  wire logic [CW-1:0]    tab_cnt,
  output logic                  busy,
  output logic [SUM_W-1:0]      best_abs,
  output logic [CW-1:0]         best_cnt
);

  logic             v2, v3;
  logic [SUM_W-1:0] cand_sum, cand_mag;
  logic [CW-1:0]    cand_cnt, mag_cnt;
  logic [CW-1:0]    tot_cnt;
  logic             better;

  assign tot_cnt = part_cnt + tab_cnt;
  assign better  = (cand_mag < best_abs) || ((cand_mag == best_abs) && (mag_cnt < best_cnt));
  assign busy    = v2 | v3;

  // advance the valid flags; an empty subset is dropped here
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v2 <= ctl.valid && (tot_cnt != '0);
      v3 <= v2;
    end
  end

  // add, then take magnitude
  always_ff @(posedge clk) begin
    cand_sum <= part_sum + tab_sum;
    cand_cnt <= tot_cnt;
    cand_mag <= cand_sum[SUM_W-1] ? (~cand_sum + SUM_W'(1)) : cand_sum;
    mag_cnt  <= cand_cnt;
  end

  // hold the best pair
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      best_abs <= '1;
      best_cnt <= '1;
    end else if (v3 && better) begin
      best_abs <= cand_mag;
      best_cnt <= mag_cnt;
    end
  end

endmodule
`default_nettype wire

>>> hdl/min_abs_subset_sum_search_core.sv
// Top level of the minimum absolute subset sum search core: element store,
// half-sum table memory and the search sequencer.
// Depends on msss_pkg and msss_eval.
//
//   channel  direction  handshake             payload
//   in       sink       in_valid / in_ready   value, last
//   out      source     out_valid / out_ready best_abs_sum, best_count
//
// Elements load one per cycle. After the last word, with n elements, h = n/2
// and r = n - h, the block builds 2^h first-half sums, each through a write,
// an element read and an update state, then scans the whole table through its
// single read port once per second-half subset.
// No input is taken from the last word until the result word is taken.
// Reset clears the sequencer, element count and best pair; the memories need no clearing.
`default_nettype none
module min_abs_subset_sum_search_core
  import msss_pkg::*;
#(
  parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS,
  parameter int VALUE_WIDTH  = DEF_VALUE_WIDTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [VALUE_WIDTH-1:0] value,
  input  wire logic                          last,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [ABS_OUT_W-1:0]               best_abs_sum,
  output logic [CNT_OUT_W-1:0]               best_count
);

  localparam int HMAX  = MAX_ELEMENTS / 2;
  localparam int RMAX  = MAX_ELEMENTS - HMAX;
  localparam int TAW   = (HMAX > 0) ? HMAX : 1;
  localparam int CW    = $clog2(MAX_ELEMENTS + 1);
  localparam int EAW   = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int SUM_W = VALUE_WIDTH + CW;
  localparam int LW    = (TAW > RMAX) ? TAW : RMAX;

  state_t state;

  logic [CW-1:0]          count, count_next, hh, rr;
  logic [TAW-1:0]         k, i, last_k;
  logic [RMAX-1:0]        j, last_j;
  logic [SUM_W-1:0]       s1, s2;
  logic [CW-1:0]          c1, c2;
  logic [EAW-1:0]         rd_addr;
  logic                   add;
  logic [VALUE_WIDTH-1:0] e_q;
  logic [SUM_W-1:0]       e_ext;
  logic                   rd_valid;
  logic [SUM_W-1:0]       tsum_q;
  logic [CW-1:0]          tcnt_q;
  logic                   in_acc;

  logic [VALUE_WIDTH-1:0] store    [MAX_ELEMENTS];
  logic [SUM_W-1:0]       tsum_mem [2**TAW];
  logic [CW-1:0]          tcnt_mem [2**TAW];

  logic [LW-1:0]  ctz_x;
  logic [EAW-1:0] ctz_pos;
  logic           ctz_add;

  eval_ctl_t        ctl;
  logic             ev_busy;
  logic [SUM_W-1:0] ev_abs;
  logic [CW-1:0]    ev_cnt;
  logic [SUM_W+ABS_OUT_W-1:0] abs_ext;
  logic [CW+CNT_OUT_W-1:0]    cnt_ext;

  assign in_ready  = (state == ST_LOAD);
  assign out_valid = (state == ST_OUT);
  assign in_acc    = in_valid && in_ready;

  assign count_next = (count < CW'(MAX_ELEMENTS)) ? count + CW'(1) : count;
  assign last_k = TAW'(((TAW+1)'(1) << hh) - (TAW+1)'(1));
  assign last_j = RMAX'(((RMAX+1)'(1) << rr) - (RMAX+1)'(1));
  assign e_ext  = {{(SUM_W-VALUE_WIDTH){e_q[VALUE_WIDTH-1]}}, e_q};

  // lowest set bit of the step counter; its Gray bit turns on when the next bit up is clear
  assign ctz_x = (state == ST_GRD) ? LW'(j) : LW'(k);
  always_comb begin
    ctz_pos = '0;
    ctz_add = 1'b1;
    for (int b = LW - 1; b >= 0; b--) begin
      if (ctz_x[b]) begin
        ctz_pos = EAW'(b);
        ctz_add = (b + 1 < LW) ? !ctz_x[(b + 1) % LW] : 1'b1;
      end
    end
  end

  // element store: write on load, read the element that flips next
  assign rd_addr = (state == ST_GRD) ? EAW'(hh) + ctz_pos : ctz_pos;
  always_ff @(posedge clk) begin
    if (in_acc && (count < CW'(MAX_ELEMENTS))) begin
      store[count[EAW-1:0]] <= value;
    end
    e_q <= store[rd_addr];
  end

  // half-sum table: written while building; read every cycle, but used only while scanning
  always_ff @(posedge clk) begin
    if (state == ST_BWR) begin
      tsum_mem[k] <= s1;
      tcnt_mem[k] <= c1;
    end
    tsum_q <= tsum_mem[i];
    tcnt_q <= tcnt_mem[i];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LOAD;
      count    <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= (state == ST_SCAN);
      unique case (state)
        ST_LOAD: begin
          if (in_acc) begin
            if (last) begin
              count <= '0;
              hh    <= count_next >> 1;
              rr    <= count_next - (count_next >> 1);
              k     <= '0;
              i     <= '0;
              j     <= '0;
              s1    <= '0;
              c1    <= '0;
              s2    <= '0;
              c2    <= '0;
              state <= ST_BWR;
            end else begin
              count <= count_next;
            end
          end
        end
        ST_BWR: begin
          if (k == last_k) begin
            state <= ST_SCAN;
          end else begin
            k     <= k + TAW'(1);
            state <= ST_BRD;
          end
        end
        ST_BRD: begin
          add   <= ctz_add;
          state <= ST_BUPD;
        end
        ST_BUPD: begin
          s1    <= add ? s1 + e_ext : s1 - e_ext;
          c1    <= add ? c1 + CW'(1) : c1 - CW'(1);
          state <= ST_BWR;
        end
        ST_SCAN: begin
          if (i == last_k) begin
            state <= ST_NEXT;
          end else begin
            i <= i + TAW'(1);
          end
        end
        ST_NEXT: begin
          if (j == last_j) begin
            state <= ST_DRAIN;
          end else begin
            j     <= j + RMAX'(1);
            state <= ST_GRD;
          end
        end
        ST_GRD: begin
          add   <= ctz_add;
          state <= ST_GUPD;
        end
        ST_GUPD: begin
          s2    <= add ? s2 + e_ext : s2 - e_ext;
          c2    <= add ? c2 + CW'(1) : c2 - CW'(1);
          i     <= '0;
          state <= ST_SCAN;
        end
        ST_DRAIN: begin
          if (!rd_valid && !ev_busy) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_ready) begin
            state <= ST_LOAD;
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

  assign ctl = '{clear: in_acc && last, valid: rd_valid};

  msss_eval #(
    .SUM_W(SUM_W),
    .CW   (CW)
  ) u_eval (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .part_sum(s2),
    .part_cnt(c2),
    .tab_sum (tsum_q),
    .tab_cnt (tcnt_q),
    .busy    (ev_busy),
    .best_abs(ev_abs),
    .best_cnt(ev_cnt)
  );

  // fit the best pair to the result word
  assign abs_ext      = {{ABS_OUT_W{1'b0}}, ev_abs};
  assign cnt_ext      = {{CNT_OUT_W{1'b0}}, ev_cnt};
  assign best_abs_sum = abs_ext[ABS_OUT_W-1:0];
  assign best_count   = cnt_ext[CNT_OUT_W-1:0];

endmodule
`default_nettype wire

>>> hdl/msss_checker.sv
// Port-level checks for the minimum absolute subset sum search core, with its bind.
// Depends on msss_pkg and min_abs_subset_sum_search_core.
`default_nettype none
module msss_props
  import msss_pkg::*;
#(
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   in_valid,
  input wire logic                   in_ready,
  input wire logic [VALUE_WIDTH-1:0] value,
  input wire logic                   last,
  input wire logic                   out_valid,
  input wire logic                   out_ready,
  input wire logic [ABS_OUT_W-1:0]   best_abs_sum,
  input wire logic [CNT_OUT_W-1:0]   best_count
);

  // hold a stalled input word
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(value) && $stable(last))
    else $error("input word changed while stalled");

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(best_abs_sum) && $stable(best_count))
    else $error("result word changed while stalled");

  // never take input while a result word waits
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input taken while result pending");

  // stop input after the final word of a set
  a_stop_after_last: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && last |=> !in_ready)
    else $error("input still open after last word");

  // a result always counts at least one member
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> best_count != '0)
    else $error("result count is zero");

endmodule

bind min_abs_subset_sum_search_core msss_props #(
  .VALUE_WIDTH(VALUE_WIDTH)
) u_msss_props (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .value       (value),
  .last        (last),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .best_abs_sum(best_abs_sum),
  .best_count  (best_count)
);
`default_nettype wire
